FILE: rtl/lrs_pkg.sv
`timescale 1ns / 1ps

package lrs_pkg;

  localparam int MAX_CHARS  = 128;
  localparam int ADDR_W     = $clog2(MAX_CHARS);
  localparam int CNT_W      = $clog2(MAX_CHARS + 1);
  localparam int SYM_W      = 8;
  localparam int OUT_W      = 7;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One classified word as it travels from front to back.
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [ADDR_W-1:0] addr;  // store slot
    logic              keep;  // slot is inside the buffer
    logic              last;  // ends the string
    logic              ovf;   // string lost a word (valid with last)
  } lrs_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lrs_q_status_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } lrs_state_e;

endpackage

FILE: rtl/longest_repeated_substring_top.sv
`timescale 1ns / 1ps

// Longest repeated substring finder. A string is loaded one word per cycle
// while busy_o is low (symbol_i, last_i) with start_i; a word is taken at a
// clock edge with start_i high and busy_o low. Up to 128 characters are
// kept; later ones are dropped and reported through overflow_o. The word
// with last_i set starts the search, which visits one pair of positions per
// cycle, walking each offset diagonal of the two-port character memory.
// Words of the next string may arrive meanwhile; two are queued and then
// busy_o rises until the search ends. The result (first longest repeat:
// start and length, both 0 when nothing repeats) is shown for exactly one
// cycle with done_o high. There is no back-pressure on the result side: the
// receiver must take it.

module longest_repeated_substring_top import lrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             last_i,
  output logic             done_o,
  output logic [OUT_W-1:0] match_start_o,
  output logic [OUT_W-1:0] match_length_o,
  output logic             overflow_o
);

  lrs_item_t     front_item, head_item;
  lrs_q_status_t q_status;
  logic          accept, pop;

  // busy only while the queue is full; the search side drains it
  assign busy_o = q_status.full;
  assign accept = start_i & ~busy_o;

  // front: numbers each word and marks it kept or dropped
  lrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .symbol_i (symbol_i),
    .last_i   (last_i),
    .item_o   (front_item)
  );

  lrs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  // back: loads the store and runs the pair search
  lrs_search u_search (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (~q_status.empty),
    .item_i         (head_item),
    .pop_o          (pop),
    .done_o         (done_o),
    .match_start_o  (match_start_o),
    .match_length_o (match_length_o),
    .overflow_o     (overflow_o)
  );

  // result strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // no repeat must report start 0
  a_zero_len_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (match_length_o == '0)) |-> (match_start_o == '0))
    else $error("empty result with nonzero start");

  // the repeat and its later copy fit in the buffer
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (({1'b0, match_start_o} + {1'b0, match_length_o}) <
                (OUT_W + 1)'(MAX_CHARS)))
    else $error("result runs past the buffer");

  // a full queue holds off new words until the search side pops
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !pop) |=> busy_o)
    else $error("queue left full state without a pop");

endmodule

FILE: rtl/lrs_front.sv
`timescale 1ns / 1ps

module lrs_front import lrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             last_i,
  output lrs_item_t        item_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic             keep;

  assign keep = (cnt_q < CNT_W'(MAX_CHARS));

  always_comb begin
    item_o.sym  = symbol_i;
    item_o.addr = cnt_q[ADDR_W-1:0];
    item_o.keep = keep;
    item_o.last = last_i;
    item_o.ovf  = drop_q | ~keep;
  end

  always_comb begin
    cnt_d  = cnt_q;
    drop_d = drop_q;
    if (accept_i) begin
      if (last_i) begin
        cnt_d  = '0;
        drop_d = 1'b0;
      end else if (keep) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

endmodule

FILE: rtl/lrs_queue.sv
`timescale 1ns / 1ps

module lrs_queue import lrs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lrs_item_t     item_i,
  input  logic          pop_i,
  output lrs_item_t     item_o,
  output lrs_q_status_t status_o
);

  lrs_item_t             slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign status_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign item_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + FIFO_PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + FIFO_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - FIFO_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/lrs_search.sv
`timescale 1ns / 1ps

module lrs_search import lrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  lrs_item_t        item_i,
  output logic             pop_o,
  output logic             done_o,
  output logic [OUT_W-1:0] match_start_o,
  output logic [OUT_W-1:0] match_length_o,
  output logic             overflow_o
);

  lrs_state_e state_q, state_d;

  logic [SYM_W-1:0]  mem_q [MAX_CHARS];
  logic [SYM_W-1:0]  rd_a_q, rd_b_q;

  logic [CNT_W-1:0]  n_q, n_d;
  logic [ADDR_W-1:0] p_q, p_d, d_q, d_d;
  logic              first_q, first_d;
  logic              ovf_q, ovf_d;

  // compare stage
  logic              s1_vld_q, s1_vld_d;
  logic              s1_first_q;
  logic [ADDR_W-1:0] s1_p_q, s1_d_q;

  logic [ADDR_W-1:0] run_q, run_d;
  logic [ADDR_W-1:0] best_len_q, best_len_d;
  logic [ADDR_W-1:0] best_start_q, best_start_d;
  logic [ADDR_W-1:0] best_dist_q, best_dist_d;

  logic              load_last;
  logic [CNT_W-1:0]  n_load;
  logic              scan;
  logic              eq, better;
  logic [CNT_W-1:0]  n_m1, p_next_diag;

  assign pop_o     = valid_i && (state_q == S_LOAD);
  assign load_last = pop_o && item_i.last;
  assign n_load    = item_i.keep ? CNT_W'(item_i.addr) + CNT_W'(1) : CNT_W'(MAX_CHARS);
  assign scan      = (state_q == S_SCAN);
  assign n_m1      = n_q - CNT_W'(1);
  // start of the next diagonal: p = n - 2 - d
  assign p_next_diag = n_q - CNT_W'(2) - CNT_W'(d_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (load_last) begin
          state_d = (n_load < CNT_W'(2)) ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if ((p_q == '0) && (CNT_W'(d_q) == n_m1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_EMIT;
      S_EMIT:  state_d = S_LOAD;
      default: state_d = S_LOAD;
    endcase
  end

  // pair walker: each diagonal from its far end toward position zero
  always_comb begin
    n_d     = n_q;
    p_d     = p_q;
    d_d     = d_q;
    first_d = first_q;
    ovf_d   = ovf_q;
    if (load_last) begin
      n_d     = n_load;
      ovf_d   = item_i.ovf;
      d_d     = ADDR_W'(1);
      p_d     = ADDR_W'(n_load - CNT_W'(2));
      first_d = 1'b1;
    end else if (scan) begin
      if (p_q == '0) begin
        d_d     = d_q + ADDR_W'(1);
        p_d     = p_next_diag[ADDR_W-1:0];
        first_d = 1'b1;
      end else begin
        p_d     = p_q - ADDR_W'(1);
        first_d = 1'b0;
      end
    end
  end

  assign s1_vld_d = scan;

  // run length of matches starting at s1_p on diagonal s1_d
  always_comb begin
    eq    = (rd_a_q == rd_b_q);
    run_d = run_q;
    if (s1_vld_q) begin
      run_d = !eq ? '0 : (s1_first_q ? ADDR_W'(1) : run_q + ADDR_W'(1));
    end
  end

  always_comb begin
    better = s1_vld_q && (run_d != '0) &&
             ((run_d > best_len_q) ||
              ((run_d == best_len_q) &&
               ((s1_p_q < best_start_q) ||
                ((s1_p_q == best_start_q) && (s1_d_q < best_dist_q)))));
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    best_dist_d  = best_dist_q;
    if (load_last) begin
      best_len_d   = '0;
      best_start_d = '0;
      best_dist_d  = '1;
    end else if (better) begin
      best_len_d   = run_d;
      best_start_d = s1_p_q;
      best_dist_d  = s1_d_q;
    end
  end

  always_comb begin
    done_o         = (state_q == S_EMIT);
    match_start_o  = OUT_W'(best_start_q);
    match_length_o = OUT_W'(best_len_q);
    overflow_o     = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      n_q          <= '0;
      p_q          <= '0;
      d_q          <= '0;
      first_q      <= 1'b0;
      ovf_q        <= 1'b0;
      s1_vld_q     <= 1'b0;
      run_q        <= '0;
      best_len_q   <= '0;
      best_start_q <= '0;
      best_dist_q  <= '1;
    end else begin
      state_q      <= state_d;
      n_q          <= n_d;
      p_q          <= p_d;
      d_q          <= d_d;
      first_q      <= first_d;
      ovf_q        <= ovf_d;
      s1_vld_q     <= s1_vld_d;
      run_q        <= run_d;
      best_len_q   <= best_len_d;
      best_start_q <= best_start_d;
      best_dist_q  <= best_dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= first_q;
    s1_p_q     <= p_q;
    s1_d_q     <= d_q;
  end

  // character store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.keep) begin
      mem_q[item_i.addr] <= item_i.sym;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan) begin
      rd_a_q <= mem_q[p_q];
      rd_b_q <= mem_q[p_q + d_q];
    end
  end

endmodule

FILE: tb/tb_longest_repeated_substring_top.sv
`timescale 1ns / 1ps

// Testbench for the longest repeated substring finder.
// Strings go in one word per accepted command; each word with last set
// yields one result. A short table of hand-picked strings runs first, then
// random strings follow. Most random strings are small, built from narrow
// alphabets or short periodic chunks so that long repeats really occur. A
// few are long enough to fill the buffer and spill past it. Every result
// is checked against a hand-typed result or an in-bench model of the search.

module tb_longest_repeated_substring_top;
  import lrs_pkg::*;

  localparam int WORD_TARGET = 1600;
  // A full buffer search can run with no word accepted and no result shown.
  localparam int IDLE_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_STR = 160;

  // Content styles for random strings.
  typedef enum int {
    GEN_ANY_BYTE,
    GEN_TWO_SYM,
    GEN_FOUR_SYM,
    GEN_PERIODIC
  } gen_style_e;

  // One row of the directed table; has_exp marks a result typed in by hand.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             lst;
    logic             has_exp;
    logic [OUT_W-1:0] e_start;
    logic [OUT_W-1:0] e_len;
    logic             e_ovf;
  } stim_row_t;

  typedef struct packed {
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] len;
    logic             ovf;
  } repeat_hit_t;

  localparam int N_ROWS = 23;

  // 'A' alone, FF FF, three zeros, ABAB, xyz, banana, 55 AA 55 AA.
  stim_row_t dir_rows [N_ROWS] = '{
    '{8'h41, 1'b1, 1'b1, 7'd0, 7'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 7'd0, 7'd1, 1'b0},
    '{8'h00, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 7'd0, 7'd2, 1'b0},
    '{8'h41, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h42, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h42, 1'b1, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h78, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h79, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h7A, 1'b1, 1'b1, 7'd0, 7'd0, 1'b0},
    '{8'h62, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h61, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h6E, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h61, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h6E, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h61, 1'b1, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h55, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'h55, 1'b0, 1'b0, 7'd0, 7'd0, 1'b0},
    '{8'hAA, 1'b1, 1'b0, 7'd0, 7'd0, 1'b0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [SYM_W-1:0] symbol_i;
  logic             last_i;
  logic             done_o;
  logic [OUT_W-1:0] match_start_o;
  logic [OUT_W-1:0] match_length_o;
  logic             overflow_o;

  // In-bench copy of the string being loaded.
  logic [SYM_W-1:0] model_chars [MAX_CHARS];
  int               model_count;
  bit               model_dropped;

  repeat_hit_t pending_hits [$];
  repeat_hit_t expected_hit;

  int mismatches;
  int words_sent;
  int strings_sent;
  int results_seen;
  int spill_strings;
  int longest_seen;
  int idle_cycles;

  longest_repeated_substring_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .symbol_i      (symbol_i),
    .last_i        (last_i),
    .done_o        (done_o),
    .match_start_o (match_start_o),
    .match_length_o(match_length_o),
    .overflow_o    (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Brute force over every pair i < j; only a strictly longer run replaces
  // the best, so ties keep the earliest pair. Overlap is allowed.
  function automatic repeat_hit_t scan_repeat();
    repeat_hit_t hit;
    int          k;
    hit = '0;
    for (int i = 0; i + 1 < model_count; i++) begin
      for (int j = i + 1; j < model_count; j++) begin
        k = 0;
        while (j + k < model_count && model_chars[i + k] == model_chars[j + k]) k++;
        if (k > int'(hit.len)) begin
          hit.len = OUT_W'(k);
          hit.start = OUT_W'(i);
        end
      end
    end
    hit.ovf = model_dropped;
    return hit;
  endfunction

  // Fold one accepted word into the model; on the last word queue the
  // expected result (the typed one when given) and clear the string.
  task automatic take_word(input logic [SYM_W-1:0] sym, input logic lst,
                           input logic use_typed, input repeat_hit_t typed);
    repeat_hit_t hit;
    if (model_count < MAX_CHARS) begin
      model_chars[model_count] = sym;
      model_count++;
    end else begin
      model_dropped = 1'b1;
    end
    if (lst) begin
      hit = scan_repeat();
      if (use_typed) hit = typed;
      if (model_dropped) spill_strings++;
      if (int'(hit.len) > longest_seen) longest_seen = hit.len;
      pending_hits.push_back(hit);
      model_count = 0;
      model_dropped = 1'b0;
      strings_sent++;
    end
  endtask

  // Drive at the falling edge, hold until an edge sees start high and busy low.
  // Idle cycles drop start and put junk on the payload.
  task automatic send_word(input logic [SYM_W-1:0] sym, input logic lst, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      start_i  <= 1'b0;
      symbol_i <= SYM_W'($urandom);
      last_i   <= 1'(($urandom));
    end
    @(negedge clk_i);
    start_i  <= 1'b1;
    symbol_i <= sym;
    last_i   <= lst;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Result checker: one word per done_o cycle, compared with the oldest entry.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_hits.size() == 0) begin
        report_mismatch("result with nothing pending, length", match_length_o, -1);
      end else begin
        expected_hit = pending_hits.pop_front();
        if (match_start_o !== expected_hit.start)
          report_mismatch("match_start", match_start_o, expected_hit.start);
        if (match_length_o !== expected_hit.len)
          report_mismatch("match_length", match_length_o, expected_hit.len);
        if (overflow_o !== expected_hit.ovf)
          report_mismatch("overflow", overflow_o, expected_hit.ovf);
      end
    end
  end

  // Watchdog: counts cycles in which neither a command nor a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no progress for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [SYM_W-1:0] str [MAX_STR];
    logic [SYM_W-1:0] chunk [4];
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] flip;
    repeat_hit_t      typed;
    gen_style_e       style;
    int               len;
    int               period;
    int               str_idx;
    bit               no_gaps;

    rst_ni        = 1'b0;
    start_i       = 1'b0;
    symbol_i      = '0;
    last_i        = 1'b0;
    model_count   = 0;
    model_dropped = 1'b0;
    mismatches    = 0;
    words_sent    = 0;
    strings_sent  = 0;
    results_seen  = 0;
    spill_strings = 0;
    longest_seen  = 0;
    idle_cycles   = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: edge bytes, zero bytes, overlap, no repeat.
    foreach (dir_rows[r]) begin
      typed.start = dir_rows[r].e_start;
      typed.len   = dir_rows[r].e_len;
      typed.ovf   = dir_rows[r].e_ovf;
      send_word(dir_rows[r].sym, dir_rows[r].lst, $urandom_range(0, 8));
      take_word(dir_rows[r].sym, dir_rows[r].lst, dir_rows[r].has_exp, typed);
    end

    // Random strings. The first three are fixed-length: exactly full,
    // spilling by 12 with the last word dropped, and one repeated byte that
    // gives the longest possible match.
    str_idx = 0;
    while (words_sent < WORD_TARGET) begin
      style = gen_style_e'($urandom_range(0, 3));
      case (str_idx)
        0: len = MAX_CHARS;
        1: len = MAX_CHARS + 12;
        2: len = MAX_CHARS + 2;
        default: begin
          if ($urandom_range(0, 99) < 3) len = $urandom_range(MAX_CHARS - 2, MAX_STR - 20);
          else len = $urandom_range(1, 16);
        end
      endcase

      base   = SYM_W'($urandom);
      flip   = SYM_W'($urandom_range(1, 255));
      period = $urandom_range(1, 4);
      foreach (chunk[c]) chunk[c] = SYM_W'($urandom);

      for (int p = 0; p < len; p++) begin
        if (str_idx == 2) begin
          str[p] = base;
        end else begin
          case (style)
            GEN_ANY_BYTE: str[p] = SYM_W'($urandom);
            GEN_TWO_SYM:  str[p] = $urandom_range(0, 1) ? base : base ^ flip;
            GEN_FOUR_SYM: str[p] = base + SYM_W'($urandom_range(0, 3));
            default: begin
              // periodic with a rare mutation to break up the runs
              if ($urandom_range(0, 9) == 0) str[p] = SYM_W'($urandom);
              else str[p] = chunk[p % period];
            end
          endcase
        end
      end

      // about a quarter of the strings go in back to back
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int p = 0; p < len; p++) begin
        send_word(str[p], p == len - 1, no_gaps ? 0 : $urandom_range(0, 8));
        take_word(str[p], p == len - 1, 1'b0, '0);
      end
      str_idx++;
    end

    @(negedge clk_i);
    start_i <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d words in %0d strings, %0d results checked, %0d mismatches.",
             words_sent, strings_sent, results_seen, mismatches);
    $display("%0d strings spilled past the buffer; longest repeat found: %0d.",
             spill_strings, longest_seen);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lrs_pkg.sv
rtl/lrs_front.sv
rtl/lrs_queue.sv
rtl/lrs_search.sv
rtl/longest_repeated_substring_top.sv
tb/tb_longest_repeated_substring_top.sv
